// ===== design/rbc_pkg.sv =====
// Shared types, codes and defaults for the region bounds checker.
`timescale 1ns / 1ps

package rbc_pkg;

    // Default table depth; the top level may override it (1 to 256).
    localparam int TABLE_ENTRIES_DEF = 16;

    // Entry index width, sized for the largest allowed table.
    localparam int IDX_W = 8;

    localparam int ADDR_W = 64;

    typedef enum logic [1:0] {
        OP_TRACK   = 2'd0,
        OP_UNTRACK = 2'd1,
        OP_CHECK   = 2'd2,
        OP_CLAMP   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_NOT_TRACKED  = 3'd1,
        STS_OVERFLOW     = 3'd2,
        STS_OUT_OF_BOUND = 3'd3,
        STS_FULL         = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_LAUNCH,
        S_WALK,
        S_DIFF,
        S_DONE
    } t_state;

    // Search beat that walks down the row of cells.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] key;
        logic              exact_hit;
        logic [IDX_W-1:0]  exact_idx;
        logic              free_hit;
        logic [IDX_W-1:0]  free_idx;
        logic              floor_hit;
        logic [ADDR_W-1:0] floor_base;
        logic [ADDR_W-1:0] floor_size;
    } t_token;

    // Table update broadcast to every cell.
    typedef struct packed {
        logic              en;
        logic              clear;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
    } t_wr;

endpackage

// ===== design/rbc_cell.sv =====
// One table entry of the region bounds checker and its search stage.
`timescale 1ns / 1ps

module rbc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbc_pkg::t_token i_tok,
    input  rbc_pkg::t_wr    i_wr,
    output rbc_pkg::t_token o_tok
);

    localparam logic [rbc_pkg::IDX_W-1:0] MY_IDX = rbc_pkg::IDX_W'(CELL_INDEX);

    logic                       r_valid;
    logic [rbc_pkg::ADDR_W-1:0] r_base;
    logic [rbc_pkg::ADDR_W-1:0] r_size;
    logic                       r_tok_valid;
    rbc_pkg::t_token            r_tok;
    rbc_pkg::t_token            n_tok;

    // Fold this entry into the passing search beat.
    always_comb begin
        n_tok = i_tok;
        if (r_valid && (r_base == i_tok.key) && !i_tok.exact_hit) begin
            n_tok.exact_hit = 1'b1;
            n_tok.exact_idx = MY_IDX;
        end
        if (!r_valid && !i_tok.free_hit) begin
            n_tok.free_hit = 1'b1;
            n_tok.free_idx = MY_IDX;
        end
        if (r_valid && (r_base <= i_tok.key) &&
            (!i_tok.floor_hit || (r_base > i_tok.floor_base))) begin
            n_tok.floor_hit  = 1'b1;
            n_tok.floor_base = r_base;
            n_tok.floor_size = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok.valid;
            if (i_wr.en && (i_wr.idx == MY_IDX)) begin
                r_valid <= !i_wr.clear;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (i_wr.en && !i_wr.clear && (i_wr.idx == MY_IDX)) begin
            r_base <= i_wr.base;
            r_size <= i_wr.size;
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok_valid;
    end

endmodule

// ===== design/region_bounds_checker_top.sv =====
// Top level of the region bounds checker: controller and row of table cells.
`timescale 1ns / 1ps

// Region bounds checker.
// Input channel: i_in_valid / o_in_stall carry one beat of opcode, address,
// offset and length. Output channel: o_out_valid / i_out_stall carry one
// beat of status and result_length. Every input beat gives one output beat.
// A beat moves at a clock edge where valid is high and stall is low.
// The table is a row of TABLE_ENTRIES cells, each holding one region. A
// search beat enters the first cell and advances one cell per cycle,
// collecting the exact base match, the lowest free slot and the region with
// the greatest base at or below the key. The controller then subtracts,
// compares, and broadcasts any table update to the cells.
// The request is captured when the input beat is accepted; the controller
// then steps through S_SUM, S_LAUNCH, S_WALK (the search beat walks the
// cell row), S_DIFF and S_DONE, where the result is loaded into the output
// register before the next beat is accepted. One item is in work at a time.
// Reset (synchronous, active low) empties the table and both channels.
// While the receiver stalls, the output beat holds; a finished result
// behind it waits in the controller until the output register frees up.
module region_bounds_checker_top #(
    parameter int TABLE_ENTRIES = rbc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_address,
    input  logic [63:0] i_offset,
    input  logic [63:0] i_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_result_length
);

    localparam int AW = rbc_pkg::ADDR_W;

    rbc_pkg::t_state  r_state;
    rbc_pkg::t_state  n_state;

    // Captured request.
    rbc_pkg::t_opcode r_op;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_offset;
    logic [AW-1:0]    r_length;

    // Access start and end, one carry bit each for overflow.
    logic [AW:0]      r_a;
    logic [AW:0]      r_e;

    // Search result and distances from the selected base.
    rbc_pkg::t_token  r_res;
    logic [AW-1:0]    r_into;
    logic [AW:0]      r_span;

    // Output register.
    logic             r_out_valid;
    logic [2:0]       r_status;
    logic [AW-1:0]    r_rlen;

    rbc_pkg::t_token  w_tok [0:TABLE_ENTRIES];
    rbc_pkg::t_token  w_launch;
    rbc_pkg::t_wr     w_wr;

    logic             w_accept;
    logic             w_out_free;
    logic             w_commit;
    logic             w_inside;
    logic [AW-1:0]    w_avail;
    rbc_pkg::t_status w_status;
    logic [AW-1:0]    w_rlen;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rbc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rbc_pkg::S_SUM;
            end
            rbc_pkg::S_SUM:    n_state = rbc_pkg::S_LAUNCH;
            rbc_pkg::S_LAUNCH: n_state = rbc_pkg::S_WALK;
            rbc_pkg::S_WALK: begin
                if (w_tok[TABLE_ENTRIES].valid) n_state = rbc_pkg::S_DIFF;
            end
            rbc_pkg::S_DIFF:   n_state = rbc_pkg::S_DONE;
            rbc_pkg::S_DONE: begin
                if (w_out_free) n_state = rbc_pkg::S_IDLE;
            end
            default:           n_state = rbc_pkg::S_IDLE;
        endcase
    end

    // Result and table update from the captured search beat.
    always_comb begin
        w_inside = r_res.floor_hit && (r_into < r_res.floor_size);
        w_avail  = r_res.floor_size - r_into;
        w_status = rbc_pkg::STS_OK;
        w_rlen   = '0;
        w_wr.en    = 1'b0;
        w_wr.clear = (r_op == rbc_pkg::OP_UNTRACK);
        w_wr.idx   = r_res.exact_hit ? r_res.exact_idx : r_res.free_idx;
        w_wr.base  = r_addr;
        w_wr.size  = r_length;
        case (r_op)
            rbc_pkg::OP_TRACK: begin
                if (r_addr != '0) begin
                    if (r_res.exact_hit || r_res.free_hit) begin
                        w_wr.en = 1'b1;
                    end else begin
                        w_status = rbc_pkg::STS_FULL;
                    end
                end
            end
            rbc_pkg::OP_UNTRACK: begin
                if (r_res.exact_hit) begin
                    w_wr.en = 1'b1;
                end else begin
                    w_status = rbc_pkg::STS_NOT_TRACKED;
                end
            end
            rbc_pkg::OP_CHECK: begin
                if (r_a[AW] || r_e[AW]) begin
                    w_status = rbc_pkg::STS_OVERFLOW;
                end else if (w_inside && (r_span > {1'b0, r_res.floor_size})) begin
                    w_status = rbc_pkg::STS_OUT_OF_BOUND;
                end
            end
            rbc_pkg::OP_CLAMP: begin
                w_rlen = (w_inside && (w_avail < r_length)) ? w_avail : r_length;
            end
            default: w_status = rbc_pkg::STS_OK;
        endcase
        // Drop the update unless the result is leaving this cycle.
        w_wr.en = w_wr.en && w_commit;
    end

    // State outputs: input stall, launch beat, commit.
    always_comb begin
        o_in_stall = 1'b1;
        w_commit   = 1'b0;
        w_launch   = '0;
        w_launch.key = (r_op == rbc_pkg::OP_CHECK) ? r_a[AW-1:0] : r_addr;
        case (r_state)
            rbc_pkg::S_IDLE:   o_in_stall = 1'b0;
            rbc_pkg::S_LAUNCH: w_launch.valid = 1'b1;
            rbc_pkg::S_DONE:   w_commit = w_out_free;
            default:           o_in_stall = 1'b1;
        endcase
    end

    assign w_tok[0] = w_launch;

    // Row of table cells.
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        rbc_cell #(
            .CELL_INDEX(k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[k]),
            .i_wr   (w_wr),
            .o_tok  (w_tok[k+1])
        );
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= rbc_pkg::t_opcode'(i_opcode);
            r_addr   <= i_address;
            r_offset <= i_offset;
            r_length <= i_length;
        end
        if (r_state == rbc_pkg::S_SUM) begin
            r_a <= {1'b0, r_addr} + {1'b0, r_offset};
        end
        if (r_state == rbc_pkg::S_LAUNCH) begin
            r_e <= {1'b0, r_a[AW-1:0]} + {1'b0, r_length};
        end
        if ((r_state == rbc_pkg::S_WALK) && w_tok[TABLE_ENTRIES].valid) begin
            r_res <= w_tok[TABLE_ENTRIES];
        end
        if (r_state == rbc_pkg::S_DIFF) begin
            r_into <= r_res.key - r_res.floor_base;
            r_span <= r_e - {1'b0, r_res.floor_base};
        end
        if (w_commit) begin
            r_status <= w_status;
            r_rlen   <= w_rlen;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_result_length = r_rlen;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the region bounds checker top level.
`timescale 1ns / 1ps

module tb;

    localparam int          ENTRIES      = rbc_pkg::TABLE_ENTRIES_DEF;
    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 9;
    localparam int          RANDOM_BEATS = 650;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          IDLE_PCT     = 13;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        rbc_pkg::t_status status;
        logic [63:0]      rlen;
    } t_region_result;

    // Scoreboard: shadow copy of the region table plus the queue of results
    // still owed by the block, oldest first.
    class t_region_scoreboard;
        bit             slot_live [ENTRIES];
        logic [63:0]    slot_base [ENTRIES];
        logic [63:0]    slot_size [ENTRIES];
        t_region_result owed_results [$];
        int             errors;
        int             beats_in;
        int             beats_out;
        int             op_seen [4];
        int             status_seen [5];

        task report_mismatch(string what);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $time, what);
        endtask

        function int find_base(logic [63:0] key);
            int i;
            for (i = 0; i < ENTRIES; i++)
                if (slot_live[i] && slot_base[i] == key)
                    return i;
            return -1;
        endfunction

        // Live entry with the greatest base at or below the key.
        function int find_floor(logic [63:0] key);
            int i;
            int best;
            best = -1;
            for (i = 0; i < ENTRIES; i++)
                if (slot_live[i] && slot_base[i] <= key &&
                    (best < 0 || slot_base[i] > slot_base[best]))
                    best = i;
            return best;
        endfunction

        function void note_beat(rbc_pkg::t_opcode op, logic [63:0] addr,
                                logic [63:0] offs, logic [63:0] len);
            t_region_result want;
            int             hit;
            int             i;
            logic [64:0]    start_sum;
            logic [64:0]    end_sum;
            logic [63:0]    into;
            logic [63:0]    avail;
            want.status = rbc_pkg::STS_OK;
            want.rlen   = '0;
            beats_in++;
            op_seen[op]++;
            case (op)
                rbc_pkg::OP_TRACK: begin
                    if (addr != '0) begin
                        hit = find_base(addr);
                        if (hit < 0)
                            for (i = ENTRIES - 1; i >= 0; i--)
                                if (!slot_live[i])
                                    hit = i;
                        if (hit >= 0) begin
                            slot_live[hit] = 1'b1;
                            slot_base[hit] = addr;
                            slot_size[hit] = len;
                        end else begin
                            want.status = rbc_pkg::STS_FULL;
                        end
                    end
                end
                rbc_pkg::OP_UNTRACK: begin
                    hit = find_base(addr);
                    if (hit < 0)
                        want.status = rbc_pkg::STS_NOT_TRACKED;
                    else
                        slot_live[hit] = 1'b0;
                end
                rbc_pkg::OP_CHECK: begin
                    start_sum = {1'b0, addr} + {1'b0, offs};
                    end_sum   = {1'b0, start_sum[63:0]} + {1'b0, len};
                    if (start_sum[64] || end_sum[64]) begin
                        want.status = rbc_pkg::STS_OVERFLOW;
                    end else begin
                        hit = find_floor(start_sum[63:0]);
                        if (hit >= 0) begin
                            into = start_sum[63:0] - slot_base[hit];
                            if (into < slot_size[hit] &&
                                end_sum[63:0] - slot_base[hit] > slot_size[hit])
                                want.status = rbc_pkg::STS_OUT_OF_BOUND;
                        end
                    end
                end
                default: begin
                    want.rlen = len;
                    hit = find_floor(addr);
                    if (hit >= 0) begin
                        into = addr - slot_base[hit];
                        if (into < slot_size[hit]) begin
                            avail = slot_size[hit] - into;
                            if (avail < want.rlen)
                                want.rlen = avail;
                        end
                    end
                end
            endcase
            owed_results.push_back(want);
        endfunction

        task check_result(logic [2:0] got_status, logic [63:0] got_len);
            t_region_result want;
            beats_out++;
            if (got_status <= 3'd4)
                status_seen[got_status]++;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result beat (status %0d) with nothing owed",
                                          got_status));
            end else begin
                want = owed_results.pop_front();
                if (got_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got_status, want.status));
                if (got_len !== want.rlen)
                    report_mismatch($sformatf("result_length %h, expected %h",
                                              got_len, want.rlen));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [63:0] i_address;
    logic [63:0] i_offset;
    logic [63:0] i_length;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [63:0] o_result_length;

    // Shared knobs: no_idle turns off idling on both sides, hold_req asks
    // the receiver for one long hold-off.
    logic no_idle;
    logic hold_req;

    t_region_scoreboard sb;

    // Targeting pool: bases the stimulus believes are tracked, with sizes.
    logic [63:0] base_pool [$];
    logic [63:0] size_pool [$];

    region_bounds_checker_top #(
        .TABLE_ENTRIES (ENTRIES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_address       (i_address),
        .i_offset        (i_offset),
        .i_length        (i_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_result_length (o_result_length)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Sample both channels on the rising edge; all stimulus moves by
    // nonblocking assignment, so these reads see the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_beat(rbc_pkg::t_opcode'(i_opcode), i_address, i_offset, i_length);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_result_length);
    end

    // Receiver: stall at random, hold off once for a long stretch so the
    // block backs up into its input, and stay open while no_idle is set.
    initial begin : receiver
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Address around a region: its edges, just past them, inside, or anywhere.
    function automatic logic [63:0] near_region(logic [63:0] base, logic [63:0] size);
        case ($urandom_range(7))
            0:       return base;
            1:       return base + size - 64'd1;
            2:       return base + size;
            3:       return base - 64'd1;
            4:       return base + ((size == '0) ? 64'd0 : rand64() % size);
            5:       return rand64();
            default: return base + 64'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [63:0] random_size();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 64'($urandom_range(1, 16));
            2:       return 64'($urandom_range(17, 4096));
            3:       return rand64();
            4:       return ALL_ONES;
            default: return 64'($urandom_range(1, 65536));
        endcase
    endfunction

    // Offer one beat and hold it until accepted. An occasional idle gap of
    // random length goes first, so gaps land on every phase of the block.
    task automatic send_beat(rbc_pkg::t_opcode op, logic [63:0] addr,
                             logic [63:0] offs, logic [63:0] len);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(1, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_address  <= addr;
        i_offset   <= offs;
        i_length   <= len;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic track_region(logic [63:0] base, logic [63:0] size);
        send_beat(rbc_pkg::OP_TRACK, base, rand64(), size);
        base_pool.push_back(base);
        size_pool.push_back(size);
    endtask

    // One random beat. Most beats aim at regions in the pool; a tenth are
    // pure noise with every field random.
    task automatic send_random_beat();
        rbc_pkg::t_opcode op;
        logic [63:0]      addr;
        logic [63:0]      offs;
        logic [63:0]      len;
        logic [63:0]      base;
        logic [63:0]      size;
        logic [63:0]      start;
        int               pick;
        int               roll;
        if (base_pool.size() > 0) begin
            pick = $urandom_range(base_pool.size() - 1);
            base = base_pool[pick];
            size = size_pool[pick];
        end else begin
            pick = -1;
            base = 64'h1000_0000;
            size = 64'h100;
        end
        offs = rand64();
        len  = rand64();
        roll = $urandom_range(99);
        if ($urandom_range(99) < 10) begin
            op   = rbc_pkg::t_opcode'($urandom_range(3));
            addr = rand64();
        end else if (roll < ((base_pool.size() < ENTRIES) ? 24 : 8)) begin
            op  = rbc_pkg::OP_TRACK;
            len = random_size();
            case ($urandom_range(9))
                0:       addr = '0;
                1, 2: begin
                    // overwrite a known base
                    addr = base;
                    if (pick >= 0)
                        size_pool[pick] = len;
                end
                3:       addr = rand64();
                default: addr = 64'h1000_0000 + 64'({$urandom_range(4095), 8'h00});
            endcase
            if (addr != '0 && addr != base && base_pool.size() < 2 * ENTRIES) begin
                base_pool.push_back(addr);
                size_pool.push_back(len);
            end
        end else if (roll < 36) begin
            op   = rbc_pkg::OP_UNTRACK;
            roll = $urandom_range(9);
            if (roll < 7 && pick >= 0) begin
                addr = base;
                base_pool.delete(pick);
                size_pool.delete(pick);
            end else if (roll == 7) begin
                addr = '0;
            end else begin
                addr = near_region(base, size);
            end
        end else if (roll < 70) begin
            op   = rbc_pkg::OP_CHECK;
            addr = near_region(base, size);
            case ($urandom_range(7))
                0:       offs = 64'($urandom_range(255));
                1:       offs = rand64();
                2:       offs = ALL_ONES - 64'($urandom_range(3));
                3, 4: begin
                    // same start, reached through the offset
                    offs = addr - base;
                    addr = base;
                end
                default: offs = '0;
            endcase
            start = addr + offs;
            case ($urandom_range(7))
                0:       len = '0;
                1:       len = rand64();
                2:       len = ALL_ONES;
                3, 4:    len = base + size - start + 64'($urandom_range(2)) - 64'd1;
                default: len = 64'($urandom_range(1, 4096));
            endcase
        end else begin
            op   = rbc_pkg::OP_CLAMP;
            addr = near_region(base, size);
            case ($urandom_range(5))
                0:       len = '0;
                1:       len = ALL_ONES;
                2:       len = rand64();
                default: len = 64'($urandom_range(1, 8192));
            endcase
        end
        send_beat(op, addr, offs, len);
    endtask

    initial begin : main_seq
        int k;
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_opcode   <= rbc_pkg::OP_TRACK;
        i_address  <= '0;
        i_offset   <= '0;
        i_length   <= '0;
        no_idle    <= 1'b0;
        hold_req   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty table, zero base, overwrite, access edges,
        // both overflow sums, top-of-space region, empty region, table full.
        send_beat(rbc_pkg::OP_TRACK,   '0, '0, ALL_ONES);
        send_beat(rbc_pkg::OP_UNTRACK, '0, '0, '0);
        send_beat(rbc_pkg::OP_CLAMP,   ALL_ONES, ALL_ONES, ALL_ONES);
        send_beat(rbc_pkg::OP_TRACK,   64'h1000, '0, 64'h100);
        send_beat(rbc_pkg::OP_TRACK,   64'h1000, '0, 64'h200);
        send_beat(rbc_pkg::OP_CHECK,   64'h1000, 64'h1F0, 64'h10);
        send_beat(rbc_pkg::OP_CHECK,   64'h1000, 64'h1F0, 64'h11);
        send_beat(rbc_pkg::OP_CHECK,   ALL_ONES, 64'h1, '0);
        send_beat(rbc_pkg::OP_CHECK,   64'hFFFF_FFFF_FFFF_FFF0, 64'h8, 64'h10);
        send_beat(rbc_pkg::OP_CLAMP,   64'h1100, '0, 64'h500);
        track_region(ALL_ONES, ALL_ONES);
        send_beat(rbc_pkg::OP_CHECK,   ALL_ONES, '0, '0);
        track_region(64'h2000, '0);
        send_beat(rbc_pkg::OP_CHECK,   64'h2000, '0, 64'h4);
        send_beat(rbc_pkg::OP_UNTRACK, 64'h1000, '0, '0);
        send_beat(rbc_pkg::OP_UNTRACK, 64'h1000, '0, '0);
        for (k = 1; k <= ENTRIES - 2; k++)
            track_region(64'h10000 * 64'(k), 64'h800);
        send_beat(rbc_pkg::OP_TRACK,   64'h7777_0000, '0, 64'h10);
        send_beat(rbc_pkg::OP_TRACK,   64'h2000, '0, 64'h40);
        send_beat(rbc_pkg::OP_CHECK,   64'h30000, 64'h7F0, 64'h20);

        // Random part. Ask for the long receiver hold-off early on and
        // drop all idling for a stretch in the middle.
        for (k = 0; k < RANDOM_BEATS; k++) begin
            if (k == 100)
                hold_req <= 1'b1;
            no_idle <= (k >= 300 && k < 420);
            send_random_beat();
        end
        i_in_valid <= 1'b0;

        // Drain: wait for every owed result, then give the block time to
        // show any stray beat.
        while (sb.owed_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * ENTRIES + 10) @(posedge i_clk);

        $display("Sent %0d beats: %0d track, %0d untrack, %0d check, %0d clamp.",
                 sb.beats_in, sb.op_seen[rbc_pkg::OP_TRACK],
                 sb.op_seen[rbc_pkg::OP_UNTRACK], sb.op_seen[rbc_pkg::OP_CHECK],
                 sb.op_seen[rbc_pkg::OP_CLAMP]);
        $display("Checked %0d results: ok %0d, untracked %0d, overflow %0d, oob %0d, full %0d.",
                 sb.beats_out, sb.status_seen[rbc_pkg::STS_OK],
                 sb.status_seen[rbc_pkg::STS_NOT_TRACKED],
                 sb.status_seen[rbc_pkg::STS_OVERFLOW],
                 sb.status_seen[rbc_pkg::STS_OUT_OF_BOUND],
                 sb.status_seen[rbc_pkg::STS_FULL]);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #(64'd5_000_000);
        $display("Timeout: results still owed %0d", sb.owed_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rbc_pkg.sv
design/rbc_cell.sv
design/region_bounds_checker_top.sv
dv/tb.sv
